[rtl/core/assert_macros.svh]
// assertion macros included by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/lcas_pkg.sv]
// types, constants and the life rule for the life generation step block
package lcas_pkg;

    localparam int GRID_WIDTH_W  = 6;
    localparam int GRID_HEIGHT_W = 11;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 11;

    localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RESET  = 6'd30;
    localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RESET = 11'd15;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [1:0] {
        S_RUN,
        S_TAIL,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic above;
        logic middle;
        logic current;
    } t_row_bits;

    typedef struct packed {
        logic shift_rows;
        logic clear_rows;
        logic flush_load;
        logic flush_shift;
    } t_cell_ctl;

    // rows given as {left, center, right}; center of mid is the cell itself
    function automatic logic life_rule(input logic [2:0] up, input logic [2:0] mid,
                                       input logic [2:0] down);
        logic [3:0] n;
        n = 4'(up[0]) + 4'(up[1]) + 4'(up[2]) + 4'(mid[0]) + 4'(mid[2])
          + 4'(down[0]) + 4'(down[1]) + 4'(down[2]);
        return (n == BIRTH_COUNT) || (mid[1] && (n == SURVIVE_COUNT));
    endfunction

endpackage

[rtl/core/lcas_cell.sv]
// one column cell: three row bits, life rule and one stage of the flush chain
module lcas_cell import lcas_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_set,
    input  t_row_bits i_left,
    input  t_row_bits i_right,
    input  logic      i_flush_next,
    output t_row_bits o_bits,
    output logic      o_life_norm,
    output logic      o_flush
);

    logic r_above, r_middle, r_current, r_flush;
    logic n_above, n_middle, n_current, n_flush;
    logic cur_eff;
    logic life_flush;

    assign cur_eff = r_current | i_set;
    assign o_bits  = '{above: r_above, middle: r_middle, current: cur_eff};
    assign o_flush = r_flush;

    assign o_life_norm = life_rule({i_left.above, r_above, i_right.above},
                                   {i_left.middle, r_middle, i_right.middle},
                                   {i_left.current, cur_eff, i_right.current});

    assign life_flush = life_rule({i_left.middle, r_middle, i_right.middle},
                                  {i_left.current, cur_eff, i_right.current},
                                  3'b000);

    always_comb begin
        n_above   = r_above;
        n_middle  = r_middle;
        n_current = cur_eff;
        if (i_ctl.clear_rows) begin
            n_above   = 1'b0;
            n_middle  = 1'b0;
            n_current = 1'b0;
        end else if (i_ctl.shift_rows) begin
            n_above   = r_middle;
            n_middle  = cur_eff;
            n_current = 1'b0;
        end
    end

    always_comb begin
        n_flush = r_flush;
        if (i_ctl.flush_load) begin
            n_flush = life_flush;
        end else if (i_ctl.flush_shift) begin
            n_flush = i_flush_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above   <= 1'b0;
            r_middle  <= 1'b0;
            r_current <= 1'b0;
        end else begin
            r_above   <= n_above;
            r_middle  <= n_middle;
            r_current <= n_current;
        end
    end

    always_ff @(posedge i_clk) begin
        r_flush <= n_flush;
    end

endmodule

[rtl/core/life_cellular_automaton_step.sv]
// top level of the life b3/s23 generation step over a raster cell stream
// Cells of the current generation enter one per item in raster order and the
// next generation leaves in raster order, one row behind, with cells beyond
// the grid edges counted as dead. A row of MAX_WIDTH column cells holds the
// two rows above and the arriving row; each cell evaluates its own rule from
// its neighbors. Inside a row one item is taken per cycle while the output
// is not stalled. After the last cell of every row after the first, input
// stalls in a tail state, since that row also yields the result of the last
// column through the single output register. After the last cell of a frame,
// input stalls while the last row's results shift out along the cell chain,
// one per cycle unless the output stalls. No clearing pass follows reset.
`include "assert_macros.svh"

module life_cellular_automaton_step import lcas_pkg::*; #(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_cell_alive,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic                     o_next_alive,
    output logic                     o_frame_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [GRID_WIDTH_W-1:0]  r_grid_width;
    logic [GRID_HEIGHT_W-1:0] r_grid_height;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_col, n_col;
    logic [RW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_x, n_x;
    logic           r_tail_flush, n_tail_flush;
    logic [CW-1:0]  r_fcnt, n_fcnt;
    logic           r_out_valid, n_out_valid;
    logic           r_out_alive, r_out_last;

    logic           out_load, out_alive_d, out_last_d;
    logic [CW-1:0]  w_m1, col_eff, sel_x;
    logic [RW-1:0]  h_m1, row_eff;
    logic           last_col, last_row, row_ge1, col_ge1;
    logic           out_free, accept;
    t_cell_ctl      cell_ctl;

    t_row_bits            cell_bits [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] life_norm, flush_bits, set_vec;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RESET;
            r_grid_height <= GRID_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GRID_WIDTH_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[GRID_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped last column and row
    always_comb begin
        if (r_grid_width == '0) begin
            w_m1 = '0;
        end else if (32'(r_grid_width) > 32'(MAX_WIDTH)) begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CW'(r_grid_width - 1'b1);
        end
        if (r_grid_height == '0) begin
            h_m1 = '0;
        end else if (32'(r_grid_height) > 32'(MAX_HEIGHT)) begin
            h_m1 = RW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = RW'(r_grid_height - 1'b1);
        end
    end

    assign col_eff  = (r_col > w_m1) ? w_m1 : r_col;
    assign row_eff  = (r_row > h_m1) ? h_m1 : r_row;
    assign last_col = (col_eff == w_m1);
    assign last_row = (row_eff == h_m1);
    assign row_ge1  = (row_eff != '0);
    assign col_ge1  = (col_eff != '0);

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = !((r_state == S_RUN) && out_free);
    assign accept   = i_valid && !o_stall;

    assign sel_x = (r_state == S_TAIL) ? r_x : (col_eff - CW'(1));

    // cell chain
    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
        t_row_bits left_bits, right_bits;
        logic      flush_next;

        assign set_vec[i] = accept && i_cell_alive && (col_eff == CW'(i));

        if (i == 0) begin : g_left_edge
            assign left_bits = '0;
        end else begin : g_left
            assign left_bits = cell_bits[i-1];
        end

        if (i == MAX_WIDTH - 1) begin : g_right_edge
            assign right_bits = '0;
            assign flush_next = 1'b0;
        end else begin : g_right
            assign right_bits = cell_bits[i+1];
            assign flush_next = flush_bits[i+1];
        end

        lcas_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_set        (set_vec[i]),
            .i_left       (left_bits),
            .i_right      (right_bits),
            .i_flush_next (flush_next),
            .o_bits       (cell_bits[i]),
            .o_life_norm  (life_norm[i]),
            .o_flush      (flush_bits[i])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (accept && last_col) begin
                    if (row_ge1) begin
                        n_state = S_TAIL;
                    end else if (last_row) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    n_state = r_tail_flush ? S_FLUSH : S_RUN;
                end
            end
            S_FLUSH: begin
                if (out_free && (r_fcnt == w_m1)) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    // datapath control
    always_comb begin
        cell_ctl     = '0;
        out_load     = 1'b0;
        out_alive_d  = 1'b0;
        out_last_d   = 1'b0;
        n_col        = r_col;
        n_row        = r_row;
        n_x          = r_x;
        n_tail_flush = r_tail_flush;
        n_fcnt       = r_fcnt;
        case (r_state)
            S_RUN: begin
                if (accept) begin
                    if (row_ge1 && col_ge1) begin
                        out_load    = 1'b1;
                        out_alive_d = life_norm[sel_x];
                    end
                    n_x          = col_eff;
                    n_tail_flush = last_row;
                    if (last_col) begin
                        n_col = '0;
                        n_row = last_row ? '0 : (row_eff + RW'(1));
                        if (!row_ge1) begin
                            cell_ctl.clear_rows = last_row;
                            cell_ctl.flush_load = last_row;
                            cell_ctl.shift_rows = !last_row;
                            n_fcnt              = '0;
                        end
                    end else begin
                        n_col = col_eff + CW'(1);
                        n_row = row_eff;
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_alive_d         = life_norm[sel_x];
                    cell_ctl.clear_rows = r_tail_flush;
                    cell_ctl.flush_load = r_tail_flush;
                    cell_ctl.shift_rows = !r_tail_flush;
                    n_fcnt              = '0;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_alive_d          = flush_bits[0];
                    out_last_d           = (r_fcnt == w_m1);
                    cell_ctl.flush_shift = 1'b1;
                    n_fcnt               = r_fcnt + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_RUN;
            r_col        <= '0;
            r_row        <= '0;
            r_tail_flush <= 1'b0;
            r_fcnt       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_col        <= n_col;
            r_row        <= n_row;
            r_tail_flush <= n_tail_flush;
            r_fcnt       <= n_fcnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        if (out_load) begin
            r_out_alive <= out_alive_d;
            r_out_last  <= out_last_d;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_next_alive = r_out_alive;
    assign o_frame_last = r_out_last;

    `ASSERT_NOW(a_flush_count, i_clk, i_rst_n, r_state == S_FLUSH, r_fcnt <= w_m1)
    `ASSERT_NOW(a_pending_counters, i_clk, i_rst_n,
                r_state == S_TAIL || r_state == S_FLUSH, r_col == '0)
    `ASSERT_NOW(a_frame_end_clear, i_clk, i_rst_n, r_out_valid && r_out_last,
                r_state == S_RUN && r_col == '0 && r_row == '0)
    `ASSERT_NEXT(a_frame_end_enter, i_clk, i_rst_n, accept && last_col && last_row,
                 r_state == S_TAIL || r_state == S_FLUSH)

endmodule
